/* rtl/dhq_pkg.sv */
// ----------------------------------------------------------------------------
// dhq_pkg: shared types and constants for the d-ary max-heap queue
// Request and result layouts, operation and status codes, and the default
// store size and degree limits used across the block.
// ----------------------------------------------------------------------------
package dhq_pkg;

  localparam int unsigned CAPACITY_DEF = 256;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned DEGREE_W = 4;

  localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd3;
  localparam logic [DEGREE_W-1:0] DEGREE_MIN   = 4'd2;
  localparam logic [DEGREE_W-1:0] DEGREE_MAX   = 4'd8;

  // Operation codes carried in the request's mode field.
  localparam logic [1:0] MODE_INSERT   = 2'd0;
  localparam logic [1:0] MODE_EXTRACT  = 2'd1;
  localparam logic [1:0] MODE_INCREASE = 2'd2;
  localparam logic [1:0] MODE_NOP      = 2'd3;

  // Status codes returned with every result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [KEY_W-1:0]  key;
    logic [INDEX_W-1:0]       index;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  value;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       count;
  } result_t;

endpackage

/* rtl/dhq_mem.sv */
// ----------------------------------------------------------------------------
// dhq_mem: heap key store
// Single-port-write, single-port-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module dhq_mem #(
  parameter int unsigned DEPTH = dhq_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = dhq_pkg::KEY_W
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/dhq_ctrl.sv */
// ----------------------------------------------------------------------------
// dhq_ctrl: heap operation sequencer
// Runs insert, extract-max and increase-key against the key store, moving a
// held key through a hole one level per pass, and produces the result strobe.
// ----------------------------------------------------------------------------
module dhq_ctrl #(
  parameter int unsigned CAPACITY = dhq_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = $clog2(CAPACITY),
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  dhq_pkg::req_t                   req,
  input  logic [dhq_pkg::DEGREE_W-1:0]    deff,
  output logic                            rd_en,
  output logic [AW-1:0]                   rd_addr,
  input  logic [dhq_pkg::KEY_W-1:0]       rd_data,
  output logic                            we,
  output logic [AW-1:0]                   wr_addr,
  output logic [dhq_pkg::KEY_W-1:0]       wr_data,
  output logic                            done,
  output dhq_pkg::result_t                result
);

  localparam int unsigned KW = dhq_pkg::KEY_W;
  localparam int unsigned SH = AW + 3;        // reciprocal scale exponent
  localparam int unsigned RW = AW + 3;        // reciprocal width
  localparam int unsigned PW = AW + RW;       // product width
  localparam int unsigned BW = AW + 4;        // child index width
  localparam int unsigned IW = CW + dhq_pkg::INDEX_W;

  // Rounded-up reciprocals of each degree. With a scale of 2^(AW+3) the
  // product's upper bits give the exact floor quotient for any AW-bit value.
  localparam int unsigned R2 = ((1 << SH) + 1) / 2;
  localparam int unsigned R3 = ((1 << SH) + 2) / 3;
  localparam int unsigned R4 = ((1 << SH) + 3) / 4;
  localparam int unsigned R5 = ((1 << SH) + 4) / 5;
  localparam int unsigned R6 = ((1 << SH) + 5) / 6;
  localparam int unsigned R7 = ((1 << SH) + 6) / 7;
  localparam int unsigned R8 = ((1 << SH) + 7) / 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EX_LAST,
    S_EX_HOLD,
    S_INC_CMP,
    S_UP_START,
    S_UP_DIV,
    S_UP_CMP,
    S_DN_BASE,
    S_DN_SCAN,
    S_DN_DEC
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [KW-1:0]   hold;
  logic [KW-1:0]   value_r;
  logic [AW-1:0]   pos;
  logic [AW-1:0]   par;
  logic [PW-1:0]   prod;
  logic [BW-1:0]   base;
  logic [dhq_pkg::DEGREE_W-1:0] cidx;
  logic            pend;
  logic [AW-1:0]   pend_idx;
  logic [KW-1:0]   best_val;
  logic [AW-1:0]   best_idx;

  logic [RW-1:0]   recip;
  logic [AW-1:0]   parent;
  logic [BW-1:0]   child;
  logic            issue;
  logic            in_range;
  logic            up_move;

  always_comb begin
    unique case (deff)
      4'd2:    recip = RW'(R2);
      4'd3:    recip = RW'(R3);
      4'd4:    recip = RW'(R4);
      4'd5:    recip = RW'(R5);
      4'd6:    recip = RW'(R6);
      4'd7:    recip = RW'(R7);
      default: recip = RW'(R8);
    endcase
  end

  assign parent   = prod[SH +: AW];
  assign child    = base + BW'(cidx);
  assign issue    = (cidx < deff) && (child < BW'(count));
  assign in_range = IW'(req.index) < IW'(count);
  assign up_move  = $signed(hold) > $signed(rd_data);
  assign busy     = (state != S_IDLE);

  // Store port control. Reads and writes never fall in the same state, so the
  // same entry is never read and written in one cycle.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    wr_addr = pos;
    wr_data = hold;
    unique case (state)
      S_IDLE: begin
        if (start && req.mode == dhq_pkg::MODE_EXTRACT && count != '0) begin
          rd_en = 1'b1;
        end
        if (start && req.mode == dhq_pkg::MODE_INCREASE && in_range) begin
          rd_en   = 1'b1;
          rd_addr = AW'(req.index);
        end
      end
      S_EX_LAST: begin
        rd_en   = 1'b1;
        rd_addr = AW'(count);
      end
      S_UP_START: begin
        we = (pos == '0);
      end
      S_UP_DIV: begin
        rd_en   = 1'b1;
        rd_addr = parent;
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (up_move) begin
          wr_data = rd_data;
        end
      end
      S_DN_SCAN: begin
        rd_en   = issue;
        rd_addr = child[AW-1:0];
      end
      S_DN_DEC: begin
        we = 1'b1;
        if (best_idx != pos) begin
          wr_data = best_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            value_r <= '0;
            hold    <= req.key;
            unique case (req.mode)
              dhq_pkg::MODE_INSERT: begin
                if (count == CW'(CAPACITY)) begin
                  done          <= 1'b1;
                  result.value  <= '0;
                  result.status <= dhq_pkg::ST_FULL;
                  result.count  <= dhq_pkg::COUNT_W'(count);
                end else begin
                  pos   <= AW'(count);
                  count <= count + 1'b1;
                  state <= S_UP_START;
                end
              end
              dhq_pkg::MODE_EXTRACT: begin
                if (count == '0) begin
                  done          <= 1'b1;
                  result.value  <= '0;
                  result.status <= dhq_pkg::ST_EMPTY;
                  result.count  <= dhq_pkg::COUNT_W'(count);
                end else begin
                  count <= count - 1'b1;
                  state <= S_EX_LAST;
                end
              end
              dhq_pkg::MODE_INCREASE: begin
                if (!in_range) begin
                  done          <= 1'b1;
                  result.value  <= '0;
                  result.status <= dhq_pkg::ST_RANGE;
                  result.count  <= dhq_pkg::COUNT_W'(count);
                end else begin
                  pos   <= AW'(req.index);
                  state <= S_INC_CMP;
                end
              end
              default: begin
                done          <= 1'b1;
                result.value  <= '0;
                result.status <= dhq_pkg::ST_OK;
                result.count  <= dhq_pkg::COUNT_W'(count);
              end
            endcase
          end
        end
        S_EX_LAST: begin
          value_r <= rd_data;
          state   <= S_EX_HOLD;
        end
        S_EX_HOLD: begin
          hold <= rd_data;
          pos  <= '0;
          if (count == '0) begin
            done          <= 1'b1;
            result.value  <= value_r;
            result.status <= dhq_pkg::ST_OK;
            result.count  <= dhq_pkg::COUNT_W'(count);
            state         <= S_IDLE;
          end else begin
            state <= S_DN_BASE;
          end
        end
        S_INC_CMP: begin
          // The entry keeps the larger of its value and the new key.
          if (!($signed(hold) > $signed(rd_data))) begin
            hold <= rd_data;
          end
          state <= S_UP_START;
        end
        S_UP_START: begin
          if (pos == '0) begin
            done          <= 1'b1;
            result.value  <= '0;
            result.status <= dhq_pkg::ST_OK;
            result.count  <= dhq_pkg::COUNT_W'(count);
            state         <= S_IDLE;
          end else begin
            prod  <= PW'(pos - 1'b1) * PW'(recip);
            state <= S_UP_DIV;
          end
        end
        S_UP_DIV: begin
          par   <= parent;
          state <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_move) begin
            pos   <= par;
            state <= S_UP_START;
          end else begin
            done          <= 1'b1;
            result.value  <= '0;
            result.status <= dhq_pkg::ST_OK;
            result.count  <= dhq_pkg::COUNT_W'(count);
            state         <= S_IDLE;
          end
        end
        S_DN_BASE: begin
          base     <= BW'(deff) * BW'(pos) + 1'b1;
          cidx     <= '0;
          pend     <= 1'b0;
          best_val <= hold;
          best_idx <= pos;
          state    <= S_DN_SCAN;
        end
        S_DN_SCAN: begin
          // One child read is issued per cycle; its data is compared in the
          // next. A strict compare keeps the first of equal largest children.
          if (pend && ($signed(rd_data) > $signed(best_val))) begin
            best_val <= rd_data;
            best_idx <= pend_idx;
          end
          if (issue) begin
            pend     <= 1'b1;
            pend_idx <= child[AW-1:0];
            cidx     <= cidx + 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_DN_DEC;
          end
        end
        S_DN_DEC: begin
          if (best_idx != pos) begin
            pos   <= best_idx;
            state <= S_DN_BASE;
          end else begin
            done          <= 1'b1;
            result.value  <= value_r;
            result.status <= dhq_pkg::ST_OK;
            result.count  <= dhq_pkg::COUNT_W'(count);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_same_entry_rw: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && we && rd_addr == wr_addr))
    else $error("store read and write hit the same entry in one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while an operation is still running");

  a_start_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither started nor answered");

  a_write_when_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> busy)
    else $error("store write while idle");

endmodule

/* rtl/dary_max_heap_queue.sv */
// ----------------------------------------------------------------------------
// dary_max_heap_queue: d-ary max-priority queue
// Keys sit in one synchronous RAM laid out as a d-ary heap; a sequencer
// performs insert, extract-max and increase-key on it.
//
// Usage:
//   A request (req: mode, key, index) is taken at a clock edge where start is
//   high and busy is low. Exactly one result (value, status, count) follows,
//   shown on result for one cycle with done high, in the cycle after the last
//   busy cycle. The receiver cannot stall; a result is taken when shown.
//   Errors (empty extract, index out of range, insert when full) and the
//   unused mode leave busy low: done rises the cycle after the request.
//   Insert runs a parent multiply, a parent read and a compare and write for
//   each parent compare, plus a root write when the key lands in the root;
//   increase-key first reads the entry. Extract reads the root and the last
//   entry, then at every level visited, the settling level included, forms
//   the first child index, reads each child there in turn and writes the entry.
//   The longest request at 256 entries is an extract at degree 2.
//   The degree register is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is low while busy or start is high. Degrees below 2 act as 2 and
//   above 8 as 8. Reset empties the queue and sets the degree to 3.
// ----------------------------------------------------------------------------
module dary_max_heap_queue #(
  parameter int unsigned CAPACITY = dhq_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  dhq_pkg::req_t                  req,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dhq_pkg::DEGREE_W-1:0]   cfg_data,
  output logic                           done,
  output dhq_pkg::result_t               result
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [dhq_pkg::DEGREE_W-1:0] degree;
  logic [dhq_pkg::DEGREE_W-1:0] deff;

  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [dhq_pkg::KEY_W-1:0] rd_data;
  logic                      we;
  logic [AW-1:0]             wr_addr;
  logic [dhq_pkg::KEY_W-1:0] wr_data;

  // A degree write never lands on the edge that takes a request.
  assign cfg_ready = !busy && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= dhq_pkg::DEGREE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      degree <= cfg_data;
    end
  end

  always_comb begin
    priority if (degree < dhq_pkg::DEGREE_MIN) begin
      deff = dhq_pkg::DEGREE_MIN;
    end else if (degree > dhq_pkg::DEGREE_MAX) begin
      deff = dhq_pkg::DEGREE_MAX;
    end else begin
      deff = degree;
    end
  end

  dhq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .deff    (deff),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .done    (done),
    .result  (result)
  );

  dhq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (dhq_pkg::KEY_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule
